// ===== src/tdc_pkg.sv =====
// Package for the fixed-key TEA decipher: round count, delta, key table,
// the stage payload type and the per-round sum helper.
// No dependencies.
package tdc_pkg;

  localparam int ROUNDS = 32;
  // Two half-round cells per round.
  localparam int CELLS = 2 * ROUNDS;

  localparam logic [31:0] TEA_DELTA = 32'h9E3779B9;

  // Row 0 is chosen by key_set = 0, row 1 by key_set = 1.
  localparam logic [31:0] KEY_TABLE [0:1][0:3] = '{
    '{32'h7AA9648F, 32'h7FAE6994, 32'hC0EFAAD5, 32'h42712C57},
    '{32'h09F4FBBD, 32'h9681884A, 32'h352027E9, 32'hF3DEE5A7}
  };

  // Word pair handed from cell to cell. src feeds the mix term and tgt is
  // the word being updated; each cell swaps them on the way out.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] tgt;
    logic        key_set;
  } tdc_word_t;

  // Round sum r * delta modulo 2^32, folded to a constant per cell.
  function automatic logic [31:0] round_sum(input int unsigned r);
    logic [63:0] prod;
    prod = 64'(r) * 64'(TEA_DELTA);
    return prod[31:0];
  endfunction

endpackage

// ===== src/tdc_cell.sv =====
// One half-round cell of the TEA decipher chain: tgt -= mix(src), then swap.
// Holds one registered beat with its valid bit. Depends on tdc_pkg.
module tdc_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tdc_pkg::tdc_word_t in_data,
  input  logic [31:0]        sum,
  input  logic               second_half,
  output logic               out_valid,
  input  logic               out_ready,
  output tdc_pkg::tdc_word_t out_data
);
  import tdc_pkg::*;

  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;
  logic [31:0] updated;
  logic        valid;
  tdc_word_t   data;

  // First half updates z with k2/k3, second half updates y with k0/k1.
  assign ka = second_half ? KEY_TABLE[in_data.key_set][0] : KEY_TABLE[in_data.key_set][2];
  assign kb = second_half ? KEY_TABLE[in_data.key_set][1] : KEY_TABLE[in_data.key_set][3];

  assign t1      = {in_data.src[27:0], 4'b0000} + ka;
  assign t2      = in_data.src + sum;
  assign t3      = {5'b00000, in_data.src[31:5]} + kb;
  assign updated = in_data.tgt - (t1 ^ t2 ^ t3);

  // Take a new beat whenever this slot is empty or draining.
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.src     <= updated;
      data.tgt     <= in_data.src;
      data.key_set <= in_data.key_set;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== src/tea_decrypt_fixed_keys.sv =====
// Top level of the fixed-key TEA decipher: a chain of half-round cells.
// Depends on tdc_pkg and tdc_cell.
//
// Channel   Dir  Payload
// s_*       in   tdata = address_word[31:0], value_word[63:32]; tuser = key_set
// m_*       out  tdata = plain_address[31:0], plain_value[63:32]
//
// There is one register per half-round cell.
// A beat can enter every cycle while m_tready is high; the chain holds up to 64 blocks in flight.
// A stall on m_tready holds the last cell; bubbles ahead of it still close up,
// so input keeps flowing until every cell is full.
// Reset clears all valid bits; payload registers are not reset.
module tea_decrypt_fixed_keys (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // address_word[31:0], value_word[63:32]
  input  logic        s_tuser,   // key_set
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // plain_address[31:0], plain_value[63:32]
);
  import tdc_pkg::*;

  logic      valid [0:CELLS];
  logic      ready [0:CELLS];
  tdc_word_t data  [0:CELLS];

  assign valid[0]        = s_tvalid;
  assign data[0].src     = s_tdata[31:0];
  assign data[0].tgt     = s_tdata[63:32];
  assign data[0].key_set = s_tuser;
  assign s_tready        = ready[0];

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    tdc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .in_valid    (valid[i]),
      .in_ready    (ready[i]),
      .in_data     (data[i]),
      .sum         (round_sum(ROUNDS - i / 2)),
      .second_half (1'((i % 2) == 1)),
      .out_valid   (valid[i+1]),
      .out_ready   (ready[i+1]),
      .out_data    (data[i+1])
    );
  end

  // After an even number of swaps src is y and tgt is z again.
  assign ready[CELLS] = m_tready;
  assign m_tvalid     = valid[CELLS];
  assign m_tdata      = {data[CELLS].tgt, data[CELLS].src};

  // A free output means every cell can move, so input is never blocked.
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output was free");

  // A stalled first cell keeps its beat.
  a_first_hold: assert property (@(posedge clk) disable iff (rst)
    valid[1] && !ready[1] |=> valid[1] && $stable(data[1]))
    else $error("first cell lost a stalled beat");

  // A stalled next-to-last cell keeps its result.
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    valid[CELLS-1] && !ready[CELLS-1] |=> valid[CELLS-1] && $stable(data[CELLS-1]))
    else $error("cell ahead of output lost a stalled beat");

endmodule
